FILE: hw/rtl/sbps_pkg.sv
// Shared types and constants for the streaming byte pattern search.
// Depends on nothing; every other file of the block imports it.

package sbps_pkg;

  localparam int DATA_W          = 8;
  localparam int OFF_W           = 64;
  localparam int LEN_W           = 5;
  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 64;
  localparam int MAX_PATTERN_DEF = 16;
  localparam int PAT_BITS        = 128;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW   = 8'd0,
    REG_PAT_HIGH  = 8'd1,
    REG_PAT_LEN   = 8'd2,
    REG_START_OFF = 8'd3
  } cfg_reg_t;

  // Current register contents, as seen by the datapath.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] pat_low;
    logic [CFG_DATA_W-1:0] pat_high;
    logic [LEN_W-1:0]      pat_len;
    logic [OFF_W-1:0]      start_off;
  } cfg_t;

  // One pending result between the search stage and the output stage.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [OFF_W-1:0] pos;
  } rec_t;

endpackage

FILE: hw/rtl/sbps_in_if.sv
// Input byte channel: valid/ready handshake with one data byte and an end marker.
// Depends on sbps_pkg.

interface sbps_in_if import sbps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

FILE: hw/rtl/sbps_out_if.sv
// Result channel: valid/ready handshake carrying the found flag and match offset.
// Depends on sbps_pkg.

interface sbps_out_if import sbps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [OFF_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

FILE: hw/rtl/sbps_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on sbps_pkg.

interface sbps_cfg_if import sbps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/streaming_byte_pattern_search.sv
// Top level of the streaming byte pattern search.
// Depends on sbps_pkg, the three channel interfaces, sbps_cfg_regs,
// sbps_search and sbps_out.
//
//   Port    | Direction | Carries
//   --------+-----------+-------------------------------------------------
//   in_ch   | sink      | data_byte (8 bits), final_byte (1 bit)
//   out_ch  | source    | found (1 bit), match_offset (64 bits)
//   cfg_ch  | sink      | index (8 bits), data (64 bits); always ready
//
// One byte transfer can be taken every cycle while the search stage's
// pending-result slot is free or draining. The byte is compared with the pattern
// combinationally; its result, if any, goes to that slot, then the output register.
// Reset is synchronous and active low; it clears the configuration registers,
// the byte count, the done flag and both valid flags. A stalled sink leaves one
// result in the output register and one in the search stage; while that second
// result waits, in_ch.ready is low for every byte, result-producing or not.

module streaming_byte_pattern_search import sbps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sbps_in_if.sink     in_ch,
  sbps_out_if.source  out_ch,
  sbps_cfg_if.sink    cfg_ch
);

  cfg_t cfg;
  rec_t rec;
  logic pop;
  logic take;

  // A byte transfer happens when both sides agree.
  assign take = in_ch.valid && in_ch.ready;

  sbps_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Window, compare and search state; the ready it returns depends only on
  // whether its pending-result slot is free or draining this cycle.
  sbps_search #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .take       (take),
    .data_byte  (in_ch.data_byte),
    .final_byte (in_ch.final_byte),
    .pop        (pop),
    .in_ready   (in_ch.ready),
    .rec        (rec)
  );

  // Final offset addition and the result register toward the sink.
  sbps_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .rec    (rec),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

FILE: hw/rtl/sbps_cfg_regs.sv
// Configuration register file of the pattern search: pattern, length, start offset.
// Depends on sbps_pkg and sbps_cfg_if.

module sbps_cfg_regs import sbps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sbps_cfg_if.sink    cfg_ch,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_PAT_LOW:   cfg_nxt.pat_low   = cfg_ch.data;
        REG_PAT_HIGH:  cfg_nxt.pat_high  = cfg_ch.data;
        REG_PAT_LEN:   cfg_nxt.pat_len   = cfg_ch.data[LEN_W-1:0];
        REG_START_OFF: cfg_nxt.start_off = cfg_ch.data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hw/rtl/sbps_search.sv
// Search stage: byte window, parallel pattern compare, search state and the
// pending-result register. Depends on sbps_pkg.

module sbps_search import sbps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              take,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              final_byte,
  input  logic              pop,
  output logic              in_ready,
  output rec_t              rec
);

  localparam int WIN_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

  logic [DATA_W-1:0] win_r   [WIN_DEPTH];
  logic [DATA_W-1:0] win_nxt [WIN_DEPTH];
  logic [OFF_W-1:0]  seen_r, seen_nxt;
  logic              done_r, done_nxt;
  rec_t              rec_r, rec_nxt;

  logic [PAT_BITS-1:0] pat_bits;
  logic                len_ok;
  logic                fill_ok;
  logic                len_hit;
  logic                hit;
  logic [OFF_W-1:0]    len_m1;

  assign pat_bits = {cfg.pat_high, cfg.pat_low};
  assign len_m1   = OFF_W'(cfg.pat_len) - OFF_W'(1);
  assign len_ok   = (cfg.pat_len != '0) && (32'(cfg.pat_len) <= MAX_PATTERN);
  assign fill_ok  = seen_r >= len_m1;

  // For each candidate length, the pattern's last byte lines up with the new
  // byte and earlier pattern bytes with older window entries.
  always_comb begin
    logic              m;
    logic [DATA_W-1:0] b;
    int                age;
    len_hit = 1'b0;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      m = 1'b1;
      for (int i = 0; i < l; i++) begin
        age = l - 1 - i;
        if (age == 0) begin
          b = data_byte;
        end else begin
          b = win_r[age-1];
        end
        if (pat_bits[DATA_W*i +: DATA_W] != b) begin
          m = 1'b0;
        end
      end
      if (LEN_W'(l) == cfg.pat_len) begin
        len_hit = m;
      end
    end
  end

  assign hit      = len_ok && fill_ok && len_hit;
  assign in_ready = !rec_r.valid || pop;
  assign rec      = rec_r;

  always_comb begin
    win_nxt  = win_r;
    seen_nxt = seen_r;
    done_nxt = done_r;
    rec_nxt  = rec_r;
    if (pop) begin
      rec_nxt.valid = 1'b0;
    end
    if (take) begin
      if (done_r) begin
        if (final_byte) begin
          seen_nxt = '0;
          done_nxt = 1'b0;
        end
      end else if (hit) begin
        rec_nxt.valid = 1'b1;
        rec_nxt.found = 1'b1;
        rec_nxt.pos   = seen_r - len_m1;
        if (final_byte) begin
          seen_nxt = '0;
        end else begin
          done_nxt = 1'b1;
        end
      end else if (final_byte) begin
        rec_nxt.valid = 1'b1;
        rec_nxt.found = 1'b0;
        rec_nxt.pos   = '0;
        seen_nxt      = '0;
      end else begin
        for (int k = WIN_DEPTH - 1; k > 0; k--) begin
          win_nxt[k] = win_r[k-1];
        end
        win_nxt[0] = data_byte;
        if (seen_r != '1) begin
          seen_nxt = seen_r + OFF_W'(1);
        end
      end
    end
  end

  // Window bytes are only read once this search has written them.
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      done_r <= 1'b0;
      rec_r  <= '0;
    end else begin
      seen_r <= seen_nxt;
      done_r <= done_nxt;
      rec_r  <= rec_nxt;
    end
  end

endmodule

FILE: hw/rtl/sbps_out.sv
// Output stage: adds the start offset to the match position and holds the
// result until the sink takes it. Depends on sbps_pkg and sbps_out_if.

module sbps_out import sbps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  rec_t        rec,
  output logic        pop,
  sbps_out_if.source  out_ch
);

  logic             valid_r, valid_nxt;
  logic             found_r, found_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;

  assign pop = rec.valid && (!valid_r || out_ch.ready);

  always_comb begin
    valid_nxt = valid_r;
    found_nxt = found_r;
    off_nxt   = off_r;
    if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
    if (pop) begin
      valid_nxt = 1'b1;
      found_nxt = rec.found;
      off_nxt   = rec.found ? (cfg.start_off + rec.pos) : '0;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    off_r   <= off_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.found        = found_r;
  assign out_ch.match_offset = off_r;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for streaming_byte_pattern_search: streams byte regions through
// the block and checks every search result against an in-bench model of the search.
// Depends on sbps_pkg, the three channel interfaces and the block's RTL.

module testbench;
  import sbps_pkg::*;

  // The window holds every byte of a full-length pattern except the newest one.
  localparam int WIN_DEPTH     = MAX_PATTERN_DEF - 1;
  // Long receiver stall, long enough to back the block up into its input.
  localparam int LONG_HOLD     = 80;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT   = 3000;
  // Size of the random part of the stimulus, in streamed bytes.
  localparam int RANDOM_ITEMS  = 1150;
  // Margin for a result to pass the search-stage and output registers after its byte.
  localparam int SETTLE_CYCLES = 4;

  typedef logic [DATA_W-1:0] byte_t;

  typedef struct {
    byte_t data;
    logic  last;
  } stream_item_t;

  typedef struct {
    logic             found;
    logic [OFF_W-1:0] offset;
  } search_answer_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sbps_in_if  in_ch ();
  sbps_out_if out_ch ();
  sbps_cfg_if cfg_ch ();

  streaming_byte_pattern_search u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Bytes waiting to be offered on the input channel, and the search answers
  // that the model has worked out but the block has not delivered yet.
  stream_item_t   stream_q[$];
  search_answer_t pending_answers[$];

  // The model's copy of the configuration registers. The pattern is kept as one
  // 128-bit word with pattern byte i in bits 8*i+7:8*i.
  logic [PAT_BITS-1:0] cur_pattern = '0;
  logic [LEN_W-1:0]    cur_len     = '0;
  logic [OFF_W-1:0]    cur_start   = '0;

  // The model's copy of the search state.
  byte_t            recent [WIN_DEPTH] = '{default: '0};
  logic [OFF_W-1:0] seen_count         = '0;
  logic             search_done        = 1'b0;

  int unsigned random_items  = 0;
  int unsigned failures      = 0;
  int unsigned idle_cycles   = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned in_wait       = 0;
  int unsigned out_wait      = 0;
  bit          in_idle_on    = 1'b0;
  bit          out_idle_on   = 1'b0;
  logic        offering;
  stream_item_t item_now;

  // Every input of the block holds a known value before the first clock edge.
  initial begin
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.final_byte = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
  end

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic clear_search();
    foreach (recent[k]) recent[k] = '0;
    seen_count  = '0;
    search_done = 1'b0;
  endtask

  // One step of the search for a byte the block has just accepted. The pattern
  // is compared against the new byte and the window of earlier bytes; the oldest
  // pattern byte lines up with the byte that is pattern length minus one old.
  task automatic advance_search(input byte_t b, input logic last);
    logic           hit;
    int unsigned    n;
    int unsigned    age;
    byte_t          aged;
    search_answer_t ans;
    // Once a match has been reported the rest of the region is swallowed; only
    // its last byte matters, because it clears the state for the next region.
    if (search_done) begin
      if (last) clear_search();
      return;
    end
    n = cur_len;
    // A zero length or one beyond the pattern size never matches, and a match
    // cannot reach back past the first byte of the region.
    hit = (n >= 1) && (n <= MAX_PATTERN_DEF) && (seen_count >= OFF_W'(n - 1));
    if (hit) begin
      for (int i = 0; i < n; i++) begin
        age = n - 1 - i;
        if (age == 0) aged = b;
        else aged = recent[age - 1];
        if (cur_pattern[8*i +: 8] != aged) hit = 1'b0;
      end
    end
    if (hit) begin
      // The offset wraps modulo 2^64 when the start offset sits near the top.
      ans.found  = 1'b1;
      ans.offset = cur_start + (seen_count - OFF_W'(n - 1));
      pending_answers = {pending_answers, ans};
      if (last) clear_search();
      else search_done = 1'b1;
    end else if (last) begin
      ans.found  = 1'b0;
      ans.offset = '0;
      pending_answers = {pending_answers, ans};
      clear_search();
    end else begin
      for (int k = WIN_DEPTH - 1; k > 0; k--) recent[k] = recent[k - 1];
      recent[0] = b;
      // The byte count sticks at its maximum instead of wrapping.
      if (seen_count != '1) seen_count++;
    end
  endtask

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PAT_LOW:   cur_pattern[CFG_DATA_W-1:0]        = data;
      REG_PAT_HIGH:  cur_pattern[PAT_BITS-1:CFG_DATA_W] = data;
      REG_PAT_LEN:   cur_len                            = data[LEN_W-1:0];
      REG_START_OFF: cur_start                          = data;
      default: ;  // writes to unknown indexes are dropped
    endcase
  endtask

  task automatic check_answer(input logic found, input logic [OFF_W-1:0] offset);
    search_answer_t want;
    if (pending_answers.size() == 0) begin
      note_failure($sformatf("unexpected result found=%0b offset=%h", found, offset));
      return;
    end
    want = pending_answers.pop_front();
    if (found !== want.found) begin
      note_failure($sformatf("found: expected %0b, got %0b", want.found, found));
    end
    if (offset !== want.offset) begin
      note_failure($sformatf("match_offset: expected %h, got %h", want.offset, offset));
    end
  endtask

  // Input driver. A byte stays offered until its transfer; after each transfer
  // it may idle, when idling is on, before offering the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_wait = 0;
    end else begin
      offering = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        advance_search(in_ch.data_byte, in_ch.final_byte);
        offering = 1'b0;
        in_wait  = in_idle_on ? $urandom_range(0, 4) : 0;
      end else if (!in_ch.valid && in_wait > 0) begin
        in_wait--;
      end
      if (!offering) begin
        if (in_wait == 0 && stream_q.size() != 0) begin
          item_now = stream_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.data_byte  <= item_now.data;
          in_ch.final_byte <= item_now.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each result transfer is checked against the oldest answer.
  // The receiver then may stall at random, and on request it stalls
  // for a long stretch so that the block has to push back on its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_answer(out_ch.found, out_ch.match_offset);
        out_wait = out_idle_on ? $urandom_range(0, 4) : 0;
      end else if (out_wait > 0) begin
        out_wait--;
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        out_wait    = out_wait + LONG_HOLD;
      end
      out_ch.ready <= (out_wait == 0);
    end
  end

  // Watchdog: the run is hung if no channel has a transfer for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_byte(input byte_t b, input logic last);
    stream_item_t it;
    it.data = b;
    it.last = last;
    stream_q = {stream_q, it};
  endtask

  // Must be entered right after a rising edge; leaves valid high for the
  // caller to keep or drop.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_cfg(idx, data);
  endtask

  // Writes all four registers back to back, optionally followed by a write to
  // an index that does not exist, and returns at a falling edge.
  task automatic configure(input logic [CFG_DATA_W-1:0] low, input logic [CFG_DATA_W-1:0] high,
                           input logic [CFG_DATA_W-1:0] len_word,
                           input logic [CFG_DATA_W-1:0] start, input bit stray);
    @(posedge clk);
    cfg_write(REG_PAT_LOW, low);
    cfg_write(REG_PAT_HIGH, high);
    cfg_write(REG_PAT_LEN, len_word);
    cfg_write(REG_START_OFF, start);
    if (stray) begin
      cfg_write(CFG_IDX_W'($urandom_range(REG_START_OFF + 1, (1 << CFG_IDX_W) - 1)),
                {$urandom, $urandom});
    end
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every byte has been taken and every answer has come back, then
  // lets the pipeline run dry, since swallowed bytes leave no answer behind.
  task automatic settle();
    do @(negedge clk);
    while (stream_q.size() != 0 || in_ch.valid || pending_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LEN_W'($urandom_range(MAX_PATTERN_DEF + 1, (1 << LEN_W) - 1));
      2, 3:    return LEN_W'(MAX_PATTERN_DEF);
      default: return LEN_W'($urandom_range(1, MAX_PATTERN_DEF - 1));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_pattern_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [OFF_W-1:0] pick_start();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return '1 - OFF_W'($urandom_range(0, 60));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // About half of the stream bytes are drawn from the current pattern so that
  // partial and shifted matches turn up often; the rest are fully random.
  function automatic byte_t stream_byte();
    int unsigned n;
    int unsigned pick;
    n = (cur_len >= 1 && cur_len <= MAX_PATTERN_DEF) ? cur_len : 1;
    pick = $urandom_range(0, n - 1);
    if ($urandom_range(0, 1) == 1) return cur_pattern[8*pick +: 8];
    return byte_t'($urandom);
  endfunction

  // Queues one region ending in its last byte. Many regions carry the pattern
  // at a random place, some only a prefix of it, and some are plain noise.
  task automatic queue_region(input int unsigned rmax);
    byte_t       body[$];
    int unsigned n;
    int unsigned at;
    int unsigned plant;
    bit          noise;
    n     = $urandom_range(1, rmax);
    noise = ($urandom_range(0, 6) == 0);
    repeat (n) body = {body, noise ? byte_t'($urandom) : stream_byte()};
    if (!noise && cur_len >= 1 && cur_len <= MAX_PATTERN_DEF && $urandom_range(0, 9) < 6) begin
      plant = cur_len;
      if ($urandom_range(0, 4) == 0) plant = $urandom_range(1, cur_len);
      at = $urandom_range(0, n - 1);
      for (int i = 0; i < plant; i++) begin
        if (at + i < body.size()) body[at + i] = cur_pattern[8*i +: 8];
        else body = {body, byte_t'(cur_pattern[8*i +: 8])};
      end
    end
    foreach (body[i]) push_byte(body[i], i == body.size() - 1);
    random_items += body.size();
  endtask

  initial begin
    int unsigned phase;
    int unsigned goal;
    int unsigned rmax;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Out of reset the pattern length is zero, so a region can only end with a
    // not-found answer.
    push_byte(8'h00, 1'b1);
    settle();

    // Three-byte pattern 00 FF 5A. First a match followed by a swallowed last
    // byte, then a match on the last byte itself, then a region that ends one
    // byte short of the pattern.
    configure(64'h0000_0000_005A_FF00, '1, 64'd3, 64'h1000, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h11, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    settle();

    // All-zero two-byte pattern with the start offset at the very top. A single
    // zero byte must not match against the cleared window, and the match at
    // position one wraps the offset around to zero.
    configure('0, '1, 64'd2, '1, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h12, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    settle();

    // A length beyond the pattern size never matches; the length word carries
    // junk in its upper bits, and a write to a missing register is dropped.
    configure('1, '1, 64'hFFFF_FFFF_FFFF_FFF1, '0, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    settle();

    // Single-byte pattern: a match one byte into the region.
    configure(64'h0000_0000_0000_00FF, '0, 64'd1, 64'd7, 1'b0);
    push_byte(8'h7E, 1'b0);
    push_byte(8'hFF, 1'b1);

    // Random phases, each with a fresh configuration. The second phase uses
    // very short regions at full input rate while the receiver stalls for a long
    // stretch, which forces the block to drop its input ready. Every phase starts
    // with the sender paused until all answers are back.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      configure(pick_pattern_word(), pick_pattern_word(),
                {$urandom, (32 - LEN_W)'($urandom), pick_len()},
                pick_start(), $urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0:       rmax = 6;
        1:       rmax = 20;
        default: rmax = 40;
      endcase
      if (phase == 1) begin
        rmax       = 3;
        in_idle_on = 1'b0;
      end
      goal = random_items + $urandom_range(80, 140);
      while (random_items < goal) queue_region(rmax);
      if (phase == 1 || $urandom_range(0, 5) == 0) hold_requests++;
      phase++;
    end

    // Let the last bytes go in, give the answers a bounded time to come out, and
    // count anything still outstanding as a failure.
    do @(negedge clk);
    while (stream_q.size() != 0 || in_ch.valid);
    for (int c = 0; c < 4 * LONG_HOLD && pending_answers.size() != 0; c++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_answers.size() != 0) begin
      note_failure($sformatf("%0d answers never arrived", pending_answers.size()));
    end

    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: streaming_byte_pattern_search.f
hw/rtl/sbps_pkg.sv
hw/rtl/sbps_in_if.sv
hw/rtl/sbps_out_if.sv
hw/rtl/sbps_cfg_if.sv
hw/rtl/sbps_cfg_regs.sv
hw/rtl/sbps_search.sv
hw/rtl/sbps_out.sv
hw/rtl/streaming_byte_pattern_search.sv
tb/testbench.sv
